// ===== sv/nrlt_pkg.sv =====
package nrlt_pkg;

    localparam int LINE_W = 20;
    localparam int COL_W  = 16;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

endpackage

// ===== sv/nrlt_store.sv =====
// single-port-write, single-port-read table; read data registered
module nrlt_store #(
    parameter int WIDTH = 84,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wen,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     ren,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wen)
        begin
            mem[waddr] <= wdata;
        end
        if (ren)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/nrlt_scan.sv =====
// running best match over entries presented one per cycle while valid is high
module nrlt_scan
    import nrlt_pkg::*;
#(
    parameter int ADDR_BITS = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 valid,
    input  logic [ADDR_BITS-1:0] addr,
    input  logic [ADDR_BITS-1:0] ent_begin,
    input  logic [ADDR_BITS-1:0] ent_end,
    input  logic [LINE_W-1:0]    ent_line,
    input  logic [COL_W-1:0]     ent_col,
    output logic [LINE_W-1:0]    best_line,
    output logic [COL_W-1:0]     best_col
);

    logic                 have_reg, have_next;
    logic [ADDR_BITS-1:0] width_reg, width_next;
    logic [LINE_W-1:0]    line_reg, line_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic                 hit;
    logic [ADDR_BITS-1:0] width;
    logic                 take;

    always_comb
    begin
        hit   = (ent_begin <= addr) && (addr < ent_end);
        width = ent_end - ent_begin;
        // strict less-than keeps the earliest entry on a tie
        take  = valid && hit && (!have_reg || (width < width_reg));

        have_next  = have_reg;
        width_next = width_reg;
        line_next  = line_reg;
        col_next   = col_reg;
        if (take)
        begin
            have_next  = 1'b1;
            width_next = width;
            line_next  = ent_line;
            col_next   = ent_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg  <= 1'b0;
            width_reg <= '0;
            line_reg  <= '0;
            col_reg   <= '0;
        end
        else if (clear)
        begin
            have_reg  <= 1'b0;
            width_reg <= '0;
            line_reg  <= '0;
            col_reg   <= '0;
        end
        else
        begin
            have_reg  <= have_next;
            width_reg <= width_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
        end
    end

    // includes the entry being evaluated this cycle
    assign best_line = line_next;
    assign best_col  = col_next;

endmodule

// ===== sv/narrowest_range_location_table.sv =====
// Insert: word accepted with start; result strobed on done in the next cycle. Never busy.
// Query: N stored entries are read one per cycle from the entry memory (one read port),
//   result strobed on done after the last entry is compared (next cycle if table empty).
//   busy is high while the scan runs, so a query occupies the block until done is strobed.
// Reset (rst_n, async, active low) empties the table; memory contents are not cleared.
// done is a one-cycle strobe; found_* hold until the next start; receiver cannot stall.
module narrowest_range_location_table
    import nrlt_pkg::*;
#(
    parameter int TABLE_DEPTH = 256,
    parameter int ADDR_BITS   = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 mode,
    input  logic [ADDR_BITS-1:0] range_begin,
    input  logic [ADDR_BITS-1:0] range_end,
    input  logic [LINE_W-1:0]    src_line,
    input  logic [COL_W-1:0]     src_column,
    input  logic [ADDR_BITS-1:0] query_address,
    output logic                 done,
    output logic [LINE_W-1:0]    found_line,
    output logic [COL_W-1:0]     found_column,
    output logic                 table_full
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int ENT_W = 2 * ADDR_BITS + LINE_W + COL_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;   // stored entries
    logic [IDX_W-1:0]     idx_reg, idx_next;       // scan read pointer
    logic [ADDR_BITS-1:0] addr_reg, addr_next;     // query address under scan
    logic                 rd_valid_reg, rd_valid_next;
    logic                 rd_last_reg, rd_last_next;
    logic                 done_reg, done_next;
    logic [LINE_W-1:0]    line_reg, line_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic                 full_reg, full_next;

    logic                 mem_wen;
    logic                 mem_ren;
    logic [ENT_W-1:0]     mem_wdata;
    logic [ENT_W-1:0]     mem_rdata;
    logic                 scan_clear;
    logic                 is_full;
    logic                 is_last;
    logic [CNT_W-1:0]     count_m1;
    logic [LINE_W-1:0]    scan_line;
    logic [COL_W-1:0]     scan_col;

    assign is_full   = (count_reg == CNT_W'(TABLE_DEPTH));
    assign count_m1  = count_reg - CNT_W'(1);
    assign is_last   = (idx_reg == count_m1[IDX_W-1:0]);
    assign mem_wdata = {range_begin, range_end, src_line, src_column};

    // entry memory: {begin, end, line, column}
    nrlt_store #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .clk   (clk),
        .wen   (mem_wen),
        .waddr (count_reg[IDX_W-1:0]),
        .wdata (mem_wdata),
        .ren   (mem_ren),
        .raddr (idx_reg),
        .rdata (mem_rdata)
    );

    // compares each entry as it comes out of the memory
    nrlt_scan #(
        .ADDR_BITS (ADDR_BITS)
    ) u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (scan_clear),
        .valid     (rd_valid_reg),
        .addr      (addr_reg),
        .ent_begin (mem_rdata[ENT_W-1 -: ADDR_BITS]),
        .ent_end   (mem_rdata[LINE_W+COL_W+ADDR_BITS-1 -: ADDR_BITS]),
        .ent_line  (mem_rdata[LINE_W+COL_W-1 -: LINE_W]),
        .ent_col   (mem_rdata[COL_W-1:0]),
        .best_line (scan_line),
        .best_col  (scan_col)
    );

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        addr_next     = addr_reg;
        rd_valid_next = 1'b0;
        rd_last_next  = 1'b0;
        done_next     = 1'b0;
        line_next     = line_reg;
        col_next      = col_reg;
        full_next     = full_reg;
        mem_wen       = 1'b0;
        mem_ren       = 1'b0;
        scan_clear    = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    done_next = 1'b1;
                    line_next = '0;
                    col_next  = '0;
                    full_next = 1'b0;
                    if (mode == MODE_INSERT)
                    begin
                        // append, or drop and flag when full
                        if (is_full)
                        begin
                            full_next = 1'b1;
                        end
                        else
                        begin
                            mem_wen    = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                    else if (count_reg != '0)
                    begin
                        // empty table answers at once; otherwise scan
                        done_next  = 1'b0;
                        addr_next  = query_address;
                        idx_next   = '0;
                        scan_clear = 1'b1;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                mem_ren       = 1'b1;
                rd_valid_next = 1'b1;
                rd_last_next  = is_last;
                idx_next      = idx_reg + IDX_W'(1);
                if (is_last)
                begin
                    state_next = ST_WAIT;
                end
            end

            ST_WAIT:
            begin
                // last entry is out of the memory this cycle
                if (rd_valid_reg && rd_last_reg)
                begin
                    done_next  = 1'b1;
                    line_next  = scan_line;
                    col_next   = scan_col;
                    full_next  = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            addr_reg     <= '0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
            line_reg     <= '0;
            col_reg      <= '0;
            full_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            addr_reg     <= addr_next;
            rd_valid_reg <= rd_valid_next;
            rd_last_reg  <= rd_last_next;
            done_reg     <= done_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            full_reg     <= full_next;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign found_line   = line_reg;
    assign found_column = col_reg;
    assign table_full   = full_reg;

endmodule

// ===== sv/nrlt_checker.sv =====
module nrlt_checker
    import nrlt_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input logic              mode,
    input logic              done,
    input logic [LINE_W-1:0] found_line,
    input logic [COL_W-1:0]  found_column,
    input logic              table_full
);

    // a dropped insert reports no location
    a_full_no_loc: assert property (@(posedge clk) disable iff (!rst_n)
        done && table_full |-> (found_line == '0) && (found_column == '0))
        else $error("table_full with nonzero location");

    // an insert answers in the next cycle
    a_insert_done: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (mode == MODE_INSERT) |=> done && !busy)
        else $error("insert word not answered in one cycle");

    // a query either answers at once or starts a scan
    a_query_go: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (mode == MODE_QUERY) |=> busy || (done && !table_full))
        else $error("query word neither answered nor scanning");

    // end of a scan always delivers a word
    a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done && !table_full)
        else $error("scan ended without a result word");

    // no result word while a scan is still running
    a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result word during scan");

endmodule

bind narrowest_range_location_table nrlt_checker u_nrlt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .done         (done),
    .found_line   (found_line),
    .found_column (found_column),
    .table_full   (table_full)
);
